[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: operation codes,
// command kinds passed from the front end to the back end, and result layout.
// ----------------------------------------------------------------------------
package tcw_pkg;

  typedef logic [7:0] char_t;
  typedef logic [7:0] attr_t;
  typedef logic [4:0] row_f_t;
  typedef logic [6:0] col_f_t;

  localparam char_t NEWLINE_CODE = 8'd10;

  localparam logic [1:0] REG_FG = 2'd0;
  localparam logic [1:0] REG_BG = 2'd1;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = 1;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_NEWLINE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    char_t     ch;
    row_f_t    read_row;
    col_f_t    read_col;
  } cmd_t;

  typedef struct packed {
    char_t  cell_char;
    attr_t  cell_attr;
    row_f_t row_now;
    col_f_t col_now;
    logic   scrolled;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

endpackage

[sv/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with a ROWS x COLUMNS cell memory.
//
// Requests enter on the in_ stream: in_tuser carries the operation (put,
// clear, read), in_tdata the character and the read coordinates. Each
// request yields one result on the out_ stream with the read cell, the
// cursor position after the request and a scroll flag. Colors are written
// on the cfg_ port (index 0 foreground, 1 background); the user must write
// them only while the block idles, as the block does not enforce it.
// A put, a newline without scroll and a read take the request from the
// queue in the idle state, then carry it out and load the result register
// in the put, done or read state. A scroll first sweeps the new bottom row
// blank, and a clear sweeps the whole memory. After reset a clearing pass
// zeroes the memory while in_tready stays low. A two-entry queue decouples
// request intake from execution; a stalled receiver holds the result register
// and execution waits at its next result while the queue still takes requests.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // cell_char[7:0], cell_attr[15:8], row_now[20:16],
                                  // col_now[27:21], scrolled[28]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  logic [3:0]            fg_r;
  logic [3:0]            bg_r;
  tcw_pkg::cmd_t         q_head;
  logic                  q_valid;
  logic                  q_pop;
  tcw_pkg::back_status_t status;
  tcw_pkg::res_t         res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 4'd15;
      bg_r <= 4'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tcw_pkg::REG_FG: fg_r <= cfg_data;
        tcw_pkg::REG_BG: bg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .status     (status),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .attr       ({bg_r, fg_r}),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {3'b000, res.scrolled, res.col_now, res.row_now,
                      res.cell_attr, res.cell_char};

endmodule

[sv/tcw_queue.sv]
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output tcw_pkg::cmd_t head,
  output logic          head_valid
);

  tcw_pkg::cmd_t              entries_r [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::Q_PTR_W-1:0] wr_ptr_r;
  logic [tcw_pkg::Q_PTR_W-1:0] rd_ptr_r;
  logic [tcw_pkg::Q_PTR_W:0]   count_r;
  logic                        do_push;
  logic                        do_pop;

  assign full       = (count_r == (tcw_pkg::Q_PTR_W + 1)'(tcw_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + tcw_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + tcw_pkg::Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (tcw_pkg::Q_PTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (tcw_pkg::Q_PTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[sv/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input requests, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,
  input  logic [1:0]            in_tuser,
  input  tcw_pkg::back_status_t status,
  input  logic                  pop,
  output tcw_pkg::cmd_t         head,
  output logic                  head_valid
);

  tcw_pkg::cmd_t  cmd;
  tcw_pkg::char_t in_char;
  tcw_pkg::row_f_t in_row;
  tcw_pkg::col_f_t in_col;
  logic           q_full;
  logic           in_range;

  assign in_char  = in_tdata[7:0];
  assign in_row   = in_tdata[12:8];
  assign in_col   = in_tdata[19:13];
  assign in_range = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));

  always_comb begin
    cmd.ch       = in_char;
    cmd.read_row = in_row;
    cmd.read_col = in_col;
    unique case (tcw_pkg::op_t'(in_tuser))
      tcw_pkg::OP_PUT: begin
        cmd.kind = (in_char == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::CMD_NEWLINE
                                                      : tcw_pkg::CMD_PUT;
      end
      tcw_pkg::OP_CLEAR: cmd.kind = tcw_pkg::CMD_CLEAR;
      tcw_pkg::OP_READ:  cmd.kind = in_range ? tcw_pkg::CMD_READ : tcw_pkg::CMD_NOP;
      default:           cmd.kind = tcw_pkg::CMD_NOP;
    endcase
  end

  assign in_tready = !q_full && !status.init_busy;

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_tvalid && in_tready),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

endmodule

[sv/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued commands against the cell memory: cursor handling, row
// scrolling through a rotating top-row pointer, blanking sweeps and reads.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcw_pkg::attr_t        attr,
  input  tcw_pkg::cmd_t         q_head,
  input  logic                  q_valid,
  output logic                  q_pop,
  output tcw_pkg::back_status_t status,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output tcw_pkg::res_t         res
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_READ,
    S_SWEEP,
    S_DONE
  } state_t;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata_r;

  state_t            state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [ADDR_W-1:0] sweep_end_r, sweep_end_nxt;
  logic [15:0]       sweep_data_r, sweep_data_nxt;
  logic              put_pend_r, put_pend_nxt;
  logic              scrolled_r, scrolled_nxt;
  tcw_pkg::char_t    ch_r, ch_nxt;
  tcw_pkg::attr_t    attr_r, attr_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_pkg::res_t     res_r, res_nxt;

  logic              we;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_free;
  logic [ADDR_W-1:0] top_base;
  logic [ADDR_W-1:0] cur_addr;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lr,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] s;
    s = {1'b0, lr} + {1'b0, top};
    if (s >= (ROW_W + 1)'(ROWS)) begin
      s = s - (ROW_W + 1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(32'(r) * 32'(COLUMNS) + 32'(c));
  endfunction

  assign out_free = !out_valid_r || out_tready;
  assign top_base = cell_addr(top_r, '0);
  assign cur_addr = cell_addr(phys_row(cur_row_r, top_r), cur_col_r);
  assign rd_addr  = cell_addr(phys_row(ROW_W'(q_head.read_row), top_r),
                              COL_W'(q_head.read_col));

  always_comb begin
    state_nxt      = state_r;
    init_nxt       = init_r;
    top_nxt        = top_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_end_nxt  = sweep_end_r;
    sweep_data_nxt = sweep_data_r;
    put_pend_nxt   = put_pend_r;
    scrolled_nxt   = scrolled_r;
    ch_nxt         = ch_r;
    attr_nxt       = attr_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    res_nxt        = res_r;
    we             = 1'b0;
    wr_addr        = sweep_addr_r;
    wr_data        = sweep_data_r;
    rd_en          = 1'b0;
    q_pop          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          ch_nxt       = q_head.ch;
          attr_nxt     = attr;
          scrolled_nxt = 1'b0;
          put_pend_nxt = (q_head.kind == tcw_pkg::CMD_PUT);
          unique case (q_head.kind) inside
            tcw_pkg::CMD_PUT, tcw_pkg::CMD_NEWLINE: begin
              if (q_head.kind == tcw_pkg::CMD_PUT && cur_col_r != COL_W'(COLUMNS)) begin
                state_nxt = S_PUT;
              end else begin
                cur_col_nxt = '0;
                if (cur_row_r < ROW_W'(ROWS - 1)) begin
                  cur_row_nxt = cur_row_r + ROW_W'(1);
                  state_nxt   = (q_head.kind == tcw_pkg::CMD_PUT) ? S_PUT : S_DONE;
                end else begin
                  scrolled_nxt   = 1'b1;
                  top_nxt        = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);
                  sweep_addr_nxt = top_base;
                  sweep_end_nxt  = top_base + ADDR_W'(COLUMNS - 1);
                  sweep_data_nxt = {attr, 8'h00};
                  state_nxt      = S_SWEEP;
                end
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              sweep_addr_nxt = '0;
              sweep_end_nxt  = ADDR_W'(CELLS - 1);
              sweep_data_nxt = {attr, 8'h00};
              state_nxt      = S_SWEEP;
            end
            tcw_pkg::CMD_READ: begin
              rd_en     = 1'b1;
              state_nxt = S_READ;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SWEEP: begin
        we = 1'b1;
        if (sweep_addr_r == sweep_end_r) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = put_pend_r ? S_PUT : S_DONE;
          end
        end else begin
          sweep_addr_nxt = sweep_addr_r + ADDR_W'(1);
        end
      end
      S_PUT: begin
        if (out_free) begin
          we                = 1'b1;
          wr_addr           = cur_addr;
          wr_data           = {attr_r, ch_r};
          cur_col_nxt       = cur_col_r + COL_W'(1);
          out_valid_nxt     = 1'b1;
          res_nxt.cell_char = '0;
          res_nxt.cell_attr = '0;
          res_nxt.row_now   = tcw_pkg::row_f_t'(cur_row_r);
          res_nxt.col_now   = tcw_pkg::col_f_t'(cur_col_r + COL_W'(1));
          res_nxt.scrolled  = scrolled_r;
          state_nxt         = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          res_nxt.cell_char = rdata_r[7:0];
          res_nxt.cell_attr = rdata_r[15:8];
          res_nxt.row_now   = tcw_pkg::row_f_t'(cur_row_r);
          res_nxt.col_now   = tcw_pkg::col_f_t'(cur_col_r);
          res_nxt.scrolled  = 1'b0;
          state_nxt         = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          res_nxt.cell_char = '0;
          res_nxt.cell_attr = '0;
          res_nxt.row_now   = tcw_pkg::row_f_t'(cur_row_r);
          res_nxt.col_now   = tcw_pkg::col_f_t'(cur_col_r);
          res_nxt.scrolled  = scrolled_r;
          state_nxt         = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      init_r       <= 1'b1;
      top_r        <= '0;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      sweep_addr_r <= '0;
      sweep_end_r  <= ADDR_W'(CELLS - 1);
      sweep_data_r <= '0;
      put_pend_r   <= 1'b0;
      scrolled_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_r       <= init_nxt;
      top_r        <= top_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_end_r  <= sweep_end_nxt;
      sweep_data_r <= sweep_data_nxt;
      put_pend_r   <= put_pend_nxt;
      scrolled_r   <= scrolled_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ch_r   <= ch_nxt;
    attr_r <= attr_nxt;
    res_r  <= res_nxt;
  end

  assign out_tvalid       = out_valid_r;
  assign res              = res_r;
  assign status.init_busy = init_r;

`ifndef NO_ASSERTIONS
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (32'(wr_addr) < 32'(CELLS)))
    else $error("cell write outside the memory");

  a_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cur_col_r) <= 32'(COLUMNS)) && (32'(cur_row_r) < 32'(ROWS))
      && (32'(top_r) < 32'(ROWS)))
    else $error("cursor or top row out of range");

  a_init_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(init_r) |-> (state_r == S_IDLE))
    else $error("initial clearing pass did not end in idle");

  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE) && !init_r)
    else $error("command taken while busy");
`endif

endmodule

[verif/tb_text_console_writer.sv]
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking testbench for the text console writer. The testbench keeps
// its own copy of the cell store, the cursor and the colors, and predicts the
// result of every accepted request. A short directed table covers reads after
// reset, out-of-range reads, the unused operation code, clear, line wrap and
// scrolling. Random phases follow, each with its own color setting. They mix
// text lines, newline bursts, reads, clears and unused codes, with random gaps
// on the request side and random stalls on the result side in non-calm phases.
// ----------------------------------------------------------------------------
module tb_text_console_writer;

  localparam int SCREEN_COLS     = 80;
  localparam int SCREEN_ROWS     = 25;
  localparam int CELL_TOTAL      = SCREEN_COLS * SCREEN_ROWS;
  localparam int RANDOM_REQUESTS = 1300;
  localparam int PHASE_COUNT     = 8;
  localparam int CLEAR_BUDGET    = 20;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam tcw_pkg::char_t LF = tcw_pkg::NEWLINE_CODE;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // char_code[7:0], read_row[12:8], read_col[19:13]
  logic [1:0]  in_tuser;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // cell_char[7:0], cell_attr[15:8], row_now[20:16],
                           // col_now[27:21], scrolled[28]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;

  text_console_writer DUT (.*);

  typedef struct {
    logic [1:0]      op;
    tcw_pkg::char_t  ch;
    tcw_pkg::row_f_t rr;
    tcw_pkg::col_f_t rc;
    int              reps;
    bit              typed;
    tcw_pkg::res_t   want;
  } plan_row_t;

  tcw_pkg::char_t shadow_char [CELL_TOTAL];
  tcw_pkg::attr_t shadow_attr [CELL_TOTAL];
  int             cursor_row;
  int             cursor_col;
  logic [3:0]     fg_nibble;
  logic [3:0]     bg_nibble;
  tcw_pkg::res_t  pending_results [$];
  plan_row_t      directed_plan [$];
  int             mismatch_count;
  int             requests_sent;
  bit             calm_phase;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL text_console_writer");
    $finish;
  end

  function automatic tcw_pkg::attr_t live_attr();
    return {bg_nibble, fg_nibble};
  endfunction

  function automatic void blank_line(int r);
    for (int c = 0; c < SCREEN_COLS; c++) begin
      shadow_char[r * SCREEN_COLS + c] = '0;
      shadow_attr[r * SCREEN_COLS + c] = live_attr();
    end
  endfunction

  function automatic bit line_feed();
    cursor_col = 0;
    if (cursor_row < SCREEN_ROWS - 1) begin
      cursor_row++;
      return 1'b0;
    end
    for (int i = 0; i < CELL_TOTAL - SCREEN_COLS; i++) begin
      shadow_char[i] = shadow_char[i + SCREEN_COLS];
      shadow_attr[i] = shadow_attr[i + SCREEN_COLS];
    end
    blank_line(SCREEN_ROWS - 1);
    return 1'b1;
  endfunction

  function automatic tcw_pkg::res_t console_step(logic [1:0] op, tcw_pkg::char_t ch,
                                                 tcw_pkg::row_f_t rr, tcw_pkg::col_f_t rc);
    tcw_pkg::res_t r;
    r = '0;
    if (op == tcw_pkg::OP_PUT) begin
      if (ch == tcw_pkg::NEWLINE_CODE) begin
        r.scrolled = line_feed();
      end else begin
        if (cursor_col >= SCREEN_COLS) r.scrolled = line_feed();
        shadow_char[cursor_row * SCREEN_COLS + cursor_col] = ch;
        shadow_attr[cursor_row * SCREEN_COLS + cursor_col] = live_attr();
        cursor_col++;
      end
    end else if (op == tcw_pkg::OP_CLEAR) begin
      for (int k = 0; k < SCREEN_ROWS; k++) blank_line(k);
    end else if (op == tcw_pkg::OP_READ) begin
      if (rr < SCREEN_ROWS && rc < SCREEN_COLS) begin
        r.cell_char = shadow_char[rr * SCREEN_COLS + rc];
        r.cell_attr = shadow_attr[rr * SCREEN_COLS + rc];
      end
    end
    r.row_now = cursor_row[4:0];
    r.col_now = cursor_col[6:0];
    return r;
  endfunction

  function automatic tcw_pkg::res_t mk_res(int c, int a, int row, int col, int s);
    tcw_pkg::res_t r;
    r.cell_char = tcw_pkg::char_t'(c);
    r.cell_attr = tcw_pkg::attr_t'(a);
    r.row_now   = tcw_pkg::row_f_t'(row);
    r.col_now   = tcw_pkg::col_f_t'(col);
    r.scrolled  = s[0];
    return r;
  endfunction

  function automatic int pause_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic plan(logic [1:0] op, tcw_pkg::char_t ch, tcw_pkg::row_f_t rr,
                      tcw_pkg::col_f_t rc, int reps, bit typed, tcw_pkg::res_t want);
    plan_row_t row;
    row.op    = op;
    row.ch    = ch;
    row.rr    = rr;
    row.rc    = rc;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_plan.push_back(row);
  endtask

  task automatic send_request(logic [1:0] op, tcw_pkg::char_t ch, tcw_pkg::row_f_t rr,
                              tcw_pkg::col_f_t rc, bit typed, tcw_pkg::res_t typed_res);
    int            gap;
    tcw_pkg::res_t predicted;
    gap = 0;
    if (!calm_phase && $urandom_range(0, 1) == 1) gap = pause_length();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, rc, rr, ch};
    do begin
      @(posedge clk);
    end while (!in_tready);
    predicted = console_step(op, ch, rr, rc);
    pending_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
  endtask

  task automatic send_random(logic [1:0] op, tcw_pkg::char_t ch);
    send_request(op, ch, tcw_pkg::row_f_t'($urandom_range(0, 31)),
                 tcw_pkg::col_f_t'($urandom_range(0, 127)), 1'b0, '0);
  endtask

  task automatic write_register(logic [1:0] idx, logic [3:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    if (idx == tcw_pkg::REG_FG) fg_nibble = val;
    else if (idx == tcw_pkg::REG_BG) bg_nibble = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic note_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    tcw_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no request waiting, expected none, actual %0h",
                 $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        note_field("cell_char", want.cell_char, out_tdata[7:0]);
        note_field("cell_attr", want.cell_attr, out_tdata[15:8]);
        note_field("row_now", {3'b000, want.row_now}, {3'b000, out_tdata[20:16]});
        note_field("col_now", {1'b0, want.col_now}, {1'b0, out_tdata[27:21]});
        note_field("scrolled", {7'd0, want.scrolled}, {7'd0, out_tdata[28]});
        note_field("padding", 8'd0, {5'd0, out_tdata[31:29]});
      end
    end
  end

  initial begin : result_sink
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= 1'b1;
        if (!calm_phase && $urandom_range(0, 7) == 0) hold = pause_length();
      end
    end
  end

  initial begin : stimulus
    int         phase_end;
    int         pick;
    int         burst;
    int         clears_left;
    logic [3:0] fg_pick;
    logic [3:0] bg_pick;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    requests_sent  = 0;
    calm_phase     = 1'b0;
    clears_left    = CLEAR_BUDGET;
    cursor_row     = 0;
    cursor_col     = 0;
    fg_nibble      = 4'd15;
    bg_nibble      = 4'd0;
    foreach (shadow_char[i]) begin
      shadow_char[i] = '0;
      shadow_attr[i] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Indexes past the register list must leave the colors untouched.
    write_register(REG_SPARE_A, 4'h3);
    write_register(REG_SPARE_B, 4'hA);

    plan(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd0,   1, 1, mk_res(0, 0, 0, 0, 0));
    plan(tcw_pkg::OP_READ,  8'h00, 5'd24, 7'd79,  1, 1, mk_res(0, 0, 0, 0, 0));
    plan(tcw_pkg::OP_READ,  8'h00, 5'd31, 7'd127, 1, 1, mk_res(0, 0, 0, 0, 0));
    plan(OP_UNUSED,         8'hFF, 5'd31, 7'd127, 1, 1, mk_res(0, 0, 0, 0, 0));
    plan(tcw_pkg::OP_PUT,   8'h41, 5'd0,  7'd0,   1, 1, mk_res(0, 0, 0, 1, 0));
    plan(tcw_pkg::OP_PUT,   8'hFF, 5'd31, 7'd127, 1, 0, '0);
    plan(tcw_pkg::OP_PUT,   8'h00, 5'd0,  7'd0,   1, 0, '0);
    plan(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd0,   1, 1, mk_res(8'h41, 8'h0F, 0, 3, 0));
    plan(tcw_pkg::OP_PUT,   LF,    5'd0,  7'd0,   1, 1, mk_res(0, 0, 1, 0, 0));
    plan(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd1,   1, 0, '0);
    plan(tcw_pkg::OP_CLEAR, 8'hFF, 5'd31, 7'd127, 1, 1, mk_res(0, 0, 1, 0, 0));
    plan(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd2,   1, 1, mk_res(0, 8'h0F, 1, 0, 0));
    plan(tcw_pkg::OP_READ,  8'h00, 5'd25, 7'd0,   1, 1, mk_res(0, 0, 1, 0, 0));
    plan(tcw_pkg::OP_READ,  8'h00, 5'd0,  7'd80,  1, 1, mk_res(0, 0, 1, 0, 0));
    plan(tcw_pkg::OP_PUT,   LF,    5'd0,  7'd0,   24, 0, '0);
    plan(tcw_pkg::OP_PUT,   8'h5A, 5'd0,  7'd0,   80, 0, '0);
    plan(tcw_pkg::OP_READ,  8'h00, 5'd24, 7'd79,  1, 0, '0);
    plan(tcw_pkg::OP_PUT,   8'h51, 5'd0,  7'd0,   1, 0, '0);
    plan(tcw_pkg::OP_PUT,   LF,    5'd0,  7'd0,   1, 0, '0);
    plan(tcw_pkg::OP_READ,  8'h00, 5'd24, 7'd0,   1, 0, '0);
    plan(tcw_pkg::OP_READ,  8'h00, 5'd23, 7'd0,   1, 0, '0);
    plan(tcw_pkg::OP_PUT,   LF,    5'd0,  7'd0,   1, 0, '0);
    plan(tcw_pkg::OP_READ,  8'h00, 5'd22, 7'd5,   1, 0, '0);

    foreach (directed_plan[i]) begin
      repeat (directed_plan[i].reps) begin
        send_request(directed_plan[i].op, directed_plan[i].ch, directed_plan[i].rr,
                     directed_plan[i].rc, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    requests_sent = 0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin
          fg_pick = 4'd0;
          bg_pick = 4'd0;
        end
        1: begin
          fg_pick = 4'd15;
          bg_pick = 4'd15;
        end
        2: begin
          fg_pick = 4'd15;
          bg_pick = 4'd0;
        end
        3: begin
          fg_pick = 4'd0;
          bg_pick = 4'd15;
        end
        default: begin
          fg_pick = 4'($urandom_range(0, 15));
          bg_pick = 4'($urandom_range(0, 15));
        end
      endcase
      write_register(tcw_pkg::REG_FG, fg_pick);
      write_register(tcw_pkg::REG_BG, bg_pick);
      if ($urandom_range(0, 1) == 1) begin
        write_register($urandom_range(0, 1) == 1 ? REG_SPARE_A : REG_SPARE_B,
                       4'($urandom_range(0, 15)));
      end
      calm_phase = (ph % 3 == 2);
      phase_end  = (ph + 1) * RANDOM_REQUESTS / PHASE_COUNT;
      while (requests_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          burst = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 20);
          repeat (burst) send_random(tcw_pkg::OP_PUT, tcw_pkg::char_t'($urandom_range(0, 255)));
          if ($urandom_range(0, 9) < 7) send_random(tcw_pkg::OP_PUT, LF);
        end else if (pick < 70) begin
          repeat ($urandom_range(1, 6)) send_random(tcw_pkg::OP_PUT, LF);
        end else if (pick < 92 || (pick >= 96 && clears_left == 0)) begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 99) < 85) begin
              send_request(tcw_pkg::OP_READ, tcw_pkg::char_t'($urandom_range(0, 255)),
                           tcw_pkg::row_f_t'($urandom_range(0, SCREEN_ROWS - 1)),
                           tcw_pkg::col_f_t'($urandom_range(0, SCREEN_COLS - 1)), 1'b0, '0);
            end else begin
              send_random(tcw_pkg::OP_READ, tcw_pkg::char_t'($urandom_range(0, 255)));
            end
          end
        end else if (pick < 96) begin
          send_random(OP_UNUSED, tcw_pkg::char_t'($urandom_range(0, 255)));
        end else begin
          clears_left--;
          send_random(tcw_pkg::OP_CLEAR, tcw_pkg::char_t'($urandom_range(0, 255)));
        end
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

endmodule
